FILE: design/stn_pkg.sv
// ============================================================================
// stn_pkg
// Shared types and constants of the sine tone unit: state codes, the
// controller-to-datapath command and status bundles, and fixed coefficients.
// ============================================================================
package stn_pkg;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SQ    = 9'b000000010,
        ST_HORN  = 9'b000000100,
        ST_YMUL  = 9'b000001000,
        ST_RND   = 9'b000010000,
        ST_ENV   = 9'b000100000,
        ST_DIV   = 9'b001000000,
        ST_SCALE = 9'b010000000,
        ST_DONE  = 9'b100000000
    } state_t;

    typedef struct packed {
        logic       load;
        logic       sq;
        logic       horn;
        logic [1:0] horn_step;
        logic       ymul;
        logic       rnd;
        logic       env;
        logic       div;
        logic       scale;
        logic       store;
    } dp_cmd_t;

    typedef struct packed {
        logic tone_now;
        logic need_div;
        logic out_free;
    } dp_status_t;

    localparam logic [1:0] REG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] REG_TONE_LENGTH = 2'd1;
    localparam logic [1:0] REG_ATTACK      = 2'd2;
    localparam logic [1:0] REG_RELEASE     = 2'd3;

    localparam logic [31:0] PHASE_STEP_RESET = 32'd42852281;
    localparam logic [19:0] TONE_LENGTH_RESET = 20'd44100;
    localparam logic [15:0] ATTACK_RESET     = 16'd441;
    localparam logic [15:0] RELEASE_RESET    = 16'd4410;

    localparam int HORN_STEPS = 4;
    localparam int DIV_STEPS  = 16;

    localparam logic [31:0] COEF_X9 = 32'd172272;
    localparam logic [31:0] HORNER_COEF [0:HORN_STEPS-1] = '{
        32'd5026994, 32'd85569306, 32'd693598668, 32'd1686629713
    };

    localparam logic [30:0] QUARTER_TURN = 31'h40000000;
    localparam logic [32:0] ROUND_HALF   = 33'h000004000;
    localparam logic [14:0] SINE_MAX     = 15'h7FFF;
    localparam logic [16:0] ENV_ONE      = 17'h10000;

endpackage

FILE: design/sine_tone_with_linear_envelope_unit.sv
// ============================================================================
// sine_tone_with_linear_envelope_unit
// Tone generator: phase accumulator, polynomial sine lookup and a linear
// attack and release envelope, one signed sample per input beat.
// ============================================================================
// A beat inside a tone runs the sine polynomial on the shared multiplier, used
// six times for the sine, then the 16-step envelope divider when the envelope
// ramps, then scaling; an idle beat goes straight to the output store. No new
// beat is taken until the result is stored, and out_stall can hold the store.
// Reset clears the phase, the sample index and the tone flag and loads the
// default configuration; the unit accepts a beat as soon as reset is released.
module sine_tone_with_linear_envelope_unit
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int LENGTH_BITS      = 20
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [14:0] sample,
    output logic               last,
    output logic               active
);

    stn_pkg::dp_cmd_t    cmd;
    stn_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    stn_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    stn_dp
    #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
        .LENGTH_BITS      (LENGTH_BITS)
    )
    u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .start_req (start_req),
        .cmd       (cmd),
        .status    (status),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sample    (sample),
        .last      (last),
        .active    (active)
    );

endmodule

FILE: design/stn_ctrl.sv
// ============================================================================
// stn_ctrl
// Sequencer of the sine tone unit: steps the datapath through the sine
// polynomial, the envelope division, scaling and the output store.
// ============================================================================
module stn_ctrl
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  stn_pkg::dp_status_t status,
    output stn_pkg::dp_cmd_t    cmd
);

    stn_pkg::state_t state_reg;
    stn_pkg::state_t state_next;
    logic [3:0]      cnt_reg;
    logic [3:0]      cnt_next;

    assign in_stall = (state_reg != stn_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.horn_step = cnt_reg[1:0];
        unique case (state_reg)
            stn_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.tone_now ? stn_pkg::ST_SQ : stn_pkg::ST_DONE;
                end
            end
            stn_pkg::ST_SQ:
            begin
                cmd.sq     = 1'b1;
                cnt_next   = '0;
                state_next = stn_pkg::ST_HORN;
            end
            stn_pkg::ST_HORN:
            begin
                cmd.horn = 1'b1;
                if (cnt_reg == 4'(stn_pkg::HORN_STEPS - 1))
                begin
                    state_next = stn_pkg::ST_YMUL;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            stn_pkg::ST_YMUL:
            begin
                cmd.ymul   = 1'b1;
                state_next = stn_pkg::ST_RND;
            end
            stn_pkg::ST_RND:
            begin
                cmd.rnd    = 1'b1;
                state_next = stn_pkg::ST_ENV;
            end
            stn_pkg::ST_ENV:
            begin
                cmd.env    = 1'b1;
                cnt_next   = '0;
                state_next = status.need_div ? stn_pkg::ST_DIV : stn_pkg::ST_SCALE;
            end
            stn_pkg::ST_DIV:
            begin
                cmd.div = 1'b1;
                if (cnt_reg == 4'(stn_pkg::DIV_STEPS - 1))
                begin
                    state_next = stn_pkg::ST_SCALE;
                end
                else
                begin
                    cnt_next = cnt_reg + 4'd1;
                end
            end
            stn_pkg::ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = stn_pkg::ST_DONE;
            end
            stn_pkg::ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.store  = 1'b1;
                    state_next = stn_pkg::ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stn_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_load_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> state_reg != stn_pkg::ST_IDLE)
        else $error("Accepted beat did not start processing.");

    a_scale_order: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == stn_pkg::ST_SCALE |->
            ($past(state_reg) == stn_pkg::ST_DIV || $past(state_reg) == stn_pkg::ST_ENV))
        else $error("Scaling entered without a finished envelope.");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == stn_pkg::ST_DONE && !status.out_free) |=>
            state_reg == stn_pkg::ST_DONE)
        else $error("Result dropped while the output was full.");

endmodule

FILE: design/stn_dp.sv
// ============================================================================
// stn_dp
// Datapath of the sine tone unit: configuration and tone state, a shared
// multiplier for the sine polynomial and scaling, a bit-serial envelope
// divider, and the output register.
// ============================================================================
module stn_dp
#(
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int LENGTH_BITS      = 20
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                start_req,
    input  stn_pkg::dp_cmd_t    cmd,
    output stn_pkg::dp_status_t status,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [14:0]  sample,
    output logic                last,
    output logic                active
);

    localparam int AW       = $clog2(SINE_TABLE_DEPTH);
    localparam int LEN_KEEP = (LENGTH_BITS < 20) ? LENGTH_BITS : 20;
    localparam logic [31:0] IDX_MASK = ~((32'd1 << (32 - AW)) - 32'd1);

    logic [31:0]            phase_step_reg;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [15:0]            attack_reg;
    logic [15:0]            release_reg;

    logic [31:0]            phase_reg;
    logic [LENGTH_BITS-1:0] index_reg;
    logic                   tone_reg;

    logic                   work_on_reg;
    logic [LENGTH_BITS-1:0] idx_w_reg;
    logic                   last_w_reg;
    logic                   neg_reg;
    logic [30:0]            x_reg;
    logic [30:0]            x2_reg;
    logic [31:0]            t_reg;
    logic [14:0]            mag_reg;
    logic [15:0]            rem_reg;
    logic [15:0]            dvs_reg;
    logic [16:0]            env_reg;

    logic                   out_valid_reg;
    logic signed [14:0]     sample_reg;
    logic                   last_reg;
    logic                   active_reg;

    logic                   tone_eff;
    logic [31:0]            phase_eff;
    logic [LENGTH_BITS-1:0] idx_eff;
    logic                   last_eff;
    logic [31:0]            pk;
    logic [30:0]            x_low;
    logic                   attack_hit;
    logic                   rel_hit;
    logic                   past_end;
    logic [LENGTH_BITS-1:0] remaining;
    logic [31:0]            mul_a;
    logic [31:0]            mul_b;
    logic [63:0]            mul_p;
    logic [17:0]            y_round;
    logic [16:0]            r2;
    logic                   q_bit;
    logic                   out_free;

    assign tone_eff  = start_req ? (len_reg != '0) : tone_reg;
    assign phase_eff = start_req ? '0 : phase_reg;
    assign idx_eff   = start_req ? '0 : index_reg;
    assign last_eff  = ({1'b0, idx_eff} + (LENGTH_BITS+1)'(1)) >= {1'b0, len_reg};
    assign pk        = phase_eff & IDX_MASK;
    assign x_low     = {1'b0, pk[29:0]};

    assign attack_hit = idx_w_reg < LENGTH_BITS'(attack_reg);
    assign rel_hit    = (release_reg != '0) &&
        (({1'b0, idx_w_reg} + (LENGTH_BITS+1)'(release_reg)) > {1'b0, len_reg});
    assign past_end   = idx_w_reg >= len_reg;
    assign remaining  = len_reg - idx_w_reg;

    always_comb
    begin
        mul_a = 32'(x_reg);
        mul_b = t_reg;
        if (cmd.sq)
        begin
            mul_b = 32'(x_reg);
        end
        else if (cmd.horn)
        begin
            mul_a = 32'(x2_reg);
        end
        else if (cmd.scale)
        begin
            mul_a = 32'(mag_reg);
            mul_b = 32'(env_reg);
        end
    end

    assign mul_p   = 64'(mul_a) * 64'(mul_b);
    assign y_round = 18'(({1'b0, t_reg} + stn_pkg::ROUND_HALF) >> 15);
    assign r2      = {rem_reg, 1'b0};
    assign q_bit   = r2 >= {1'b0, dvs_reg};
    assign out_free = !out_valid_reg || !out_stall;

    assign status.tone_now = tone_eff;
    assign status.need_div = attack_hit || (rel_hit && !past_end);
    assign status.out_free = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg <= stn_pkg::PHASE_STEP_RESET;
            len_reg        <= LENGTH_BITS'(stn_pkg::TONE_LENGTH_RESET);
            attack_reg     <= stn_pkg::ATTACK_RESET;
            release_reg    <= stn_pkg::RELEASE_RESET;
            phase_reg      <= '0;
            index_reg      <= '0;
            tone_reg       <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    stn_pkg::REG_PHASE_STEP:  phase_step_reg <= cfg_data;
                    stn_pkg::REG_TONE_LENGTH: len_reg <= LENGTH_BITS'(cfg_data[LEN_KEEP-1:0]);
                    stn_pkg::REG_ATTACK:      attack_reg <= cfg_data[15:0];
                    stn_pkg::REG_RELEASE:     release_reg <= cfg_data[15:0];
                endcase
            end
            if (cmd.load)
            begin
                if (tone_eff)
                begin
                    phase_reg <= phase_eff + phase_step_reg;
                    index_reg <= idx_eff + LENGTH_BITS'(1);
                    tone_reg  <= !last_eff;
                end
                else
                begin
                    phase_reg <= phase_eff;
                    index_reg <= idx_eff;
                    tone_reg  <= 1'b0;
                end
            end
            if (cmd.store)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            work_on_reg <= tone_eff;
            idx_w_reg   <= idx_eff;
            last_w_reg  <= last_eff;
            neg_reg     <= pk[31];
            x_reg       <= pk[30] ? (stn_pkg::QUARTER_TURN - x_low) : x_low;
        end
        if (cmd.sq)
        begin
            x2_reg <= mul_p[60:30];
            t_reg  <= stn_pkg::COEF_X9;
        end
        if (cmd.horn)
        begin
            t_reg <= stn_pkg::HORNER_COEF[cmd.horn_step] - mul_p[61:30];
        end
        if (cmd.ymul)
        begin
            t_reg <= mul_p[61:30];
        end
        if (cmd.rnd)
        begin
            mag_reg <= (y_round > 18'(stn_pkg::SINE_MAX)) ? stn_pkg::SINE_MAX : y_round[14:0];
        end
        if (cmd.env)
        begin
            if (attack_hit)
            begin
                rem_reg <= idx_w_reg[15:0];
                dvs_reg <= attack_reg;
                env_reg <= '0;
            end
            else if (rel_hit)
            begin
                rem_reg <= remaining[15:0];
                dvs_reg <= release_reg;
                env_reg <= '0;
            end
            else
            begin
                env_reg <= stn_pkg::ENV_ONE;
            end
        end
        if (cmd.div)
        begin
            rem_reg <= q_bit ? 16'(r2 - {1'b0, dvs_reg}) : r2[15:0];
            env_reg <= {env_reg[15:0], q_bit};
        end
        if (cmd.scale)
        begin
            mag_reg <= mul_p[31:17];
        end
        if (cmd.store)
        begin
            if (work_on_reg)
            begin
                sample_reg <= neg_reg ? -$signed(mag_reg) : $signed(mag_reg);
            end
            else
            begin
                sample_reg <= '0;
            end
            last_reg   <= work_on_reg && last_w_reg;
            active_reg <= work_on_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;
    assign last      = last_reg;
    assign active    = active_reg;

    a_idle_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !active_reg) |-> (sample_reg == '0 && !last_reg))
        else $error("Idle beat carries a nonzero sample or a last mark.");

    a_store_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.store |-> out_free)
        else $error("Output register overwritten while still held.");

    a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> env_reg <= stn_pkg::ENV_ONE)
        else $error("Envelope exceeds one.");

endmodule
